/* src/fcgi_pkg.sv */
package fcgi_pkg;

    // Record framing
    localparam int HDR_BYTES = 8;
    localparam int HDR_CNT_W = $clog2(HDR_BYTES + 1);
    localparam int HDR_POS_W = $clog2(HDR_BYTES);

    // Header byte positions
    localparam logic [HDR_POS_W-1:0] POS_VERSION = 3'd0;
    localparam logic [HDR_POS_W-1:0] POS_TYPE    = 3'd1;
    localparam logic [HDR_POS_W-1:0] POS_RID_HI  = 3'd2;
    localparam logic [HDR_POS_W-1:0] POS_RID_LO  = 3'd3;
    localparam logic [HDR_POS_W-1:0] POS_CLEN_HI = 3'd4;
    localparam logic [HDR_POS_W-1:0] POS_CLEN_LO = 3'd5;
    localparam logic [HDR_POS_W-1:0] POS_PLEN    = 3'd6;
    localparam logic [HDR_POS_W-1:0] POS_LAST    = 3'd7;

    // Byte phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_PADDING = 2'd2;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified byte, as passed from front to back
    typedef struct packed {
        logic [1:0]           phase;
        logic [7:0]           data;
        logic [HDR_POS_W-1:0] hdr_pos;
        logic                 hdr_done;
        logic [15:0]          body_index;
        logic                 body_last;
        logic                 rec_done;
    } fcgi_entry_t;

endpackage

/* src/fastcgi_record_deframer.sv */
// Path: an accepted byte is classified combinationally in the front, written to
// the queue, and then loaded into the result register when the slot is free.
// Throughput: one byte per clock while the queue has room and results are popped,
// set by the classify step and the single result register; a 4-entry queue between.
// Reset: rst_n asynchronous, active low; clears counters, queue and result valid.
module fastcgi_record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  phase,
    output logic [7:0]  byte_out,
    output logic        header_done,
    output logic [7:0]  protocol_version,
    output logic [7:0]  record_type,
    output logic [15:0] request_id,
    output logic [15:0] content_length,
    output logic [7:0]  padding_length,
    output logic [15:0] body_index,
    output logic        body_last,
    output logic        record_done
);

    fcgi_pkg::fcgi_entry_t front_entry;
    fcgi_pkg::fcgi_entry_t q_entry;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_rd;
    logic                  accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    fcgi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .entry     (front_entry)
    );

    fcgi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_entry  (front_entry),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_entry  (q_entry),
        .not_empty (q_not_empty)
    );

    fcgi_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_entry          (q_entry),
        .q_rd             (q_rd),
        .pop              (pop),
        .empty            (empty),
        .phase            (phase),
        .byte_out         (byte_out),
        .header_done      (header_done),
        .protocol_version (protocol_version),
        .record_type      (record_type),
        .request_id       (request_id),
        .content_length   (content_length),
        .padding_length   (padding_length),
        .body_index       (body_index),
        .body_last        (body_last),
        .record_done      (record_done)
    );

endmodule

/* src/fcgi_front.sv */
module fcgi_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    output fcgi_pkg::fcgi_entry_t entry
);

    logic [fcgi_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]                    clen_reg, clen_next;
    logic [7:0]                     plen_reg, plen_next;
    logic [15:0]                    body_cnt_reg, body_cnt_next;
    logic [7:0]                     pad_cnt_reg, pad_cnt_next;
    logic [15:0]                    body_inc;
    logic [8:0]                     pad_inc;
    logic                           in_header;
    logic                           in_content;

    assign body_inc   = body_cnt_reg + 16'd1;
    assign pad_inc    = {1'b0, pad_cnt_reg} + 9'd1;
    assign in_header  = hdr_cnt_reg < fcgi_pkg::HDR_CNT_W'(fcgi_pkg::HDR_BYTES);
    assign in_content = body_cnt_reg < clen_reg;

    // Classify the request byte and advance the record counters
    always_comb
    begin
        entry            = '0;
        entry.data       = data_byte;
        entry.hdr_pos    = hdr_cnt_reg[fcgi_pkg::HDR_POS_W-1:0];
        hdr_cnt_next     = hdr_cnt_reg;
        clen_next        = clen_reg;
        plen_next        = plen_reg;
        body_cnt_next    = body_cnt_reg;
        pad_cnt_next     = pad_cnt_reg;
        if (in_header)
        begin
            entry.phase  = fcgi_pkg::PH_HEADER;
            hdr_cnt_next = hdr_cnt_reg + fcgi_pkg::HDR_CNT_W'(1);
            case (entry.hdr_pos)
                fcgi_pkg::POS_CLEN_HI: clen_next = {data_byte, clen_reg[7:0]};
                fcgi_pkg::POS_CLEN_LO: clen_next = {clen_reg[15:8], data_byte};
                fcgi_pkg::POS_PLEN:    plen_next = data_byte;
                default:               clen_next = clen_reg;
            endcase
            if (entry.hdr_pos == fcgi_pkg::POS_LAST)
            begin
                entry.hdr_done = 1'b1;
                entry.rec_done = (clen_reg == 16'd0) && (plen_reg == 8'd0);
            end
        end
        else if (in_content)
        begin
            entry.phase      = fcgi_pkg::PH_CONTENT;
            entry.hdr_done   = 1'b1;
            entry.body_index = body_cnt_reg;
            entry.body_last  = body_inc == clen_reg;
            entry.rec_done   = entry.body_last && (plen_reg == 8'd0);
            body_cnt_next    = body_inc;
        end
        else
        begin
            entry.phase    = fcgi_pkg::PH_PADDING;
            entry.hdr_done = 1'b1;
            entry.rec_done = pad_inc >= {1'b0, plen_reg};
            pad_cnt_next   = pad_inc[7:0];
        end
        // Start the next record after its last byte
        if (entry.rec_done)
        begin
            hdr_cnt_next  = '0;
            body_cnt_next = '0;
            pad_cnt_next  = '0;
        end
    end

    // Hold counters until a request arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg  <= '0;
            clen_reg     <= '0;
            plen_reg     <= '0;
            body_cnt_reg <= '0;
            pad_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            hdr_cnt_reg  <= hdr_cnt_next;
            clen_reg     <= clen_next;
            plen_reg     <= plen_next;
            body_cnt_reg <= body_cnt_next;
            pad_cnt_reg  <= pad_cnt_next;
        end
    end

    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= fcgi_pkg::HDR_CNT_W'(fcgi_pkg::HDR_BYTES))
        else $error("header count out of range");

    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && entry.rec_done |=> hdr_cnt_reg == '0 && body_cnt_reg == '0
            && pad_cnt_reg == '0)
        else $error("record end did not restart the parser");

    a_content_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept && entry.phase == fcgi_pkg::PH_CONTENT |-> body_cnt_reg < clen_reg)
        else $error("content byte beyond content length");

endmodule

/* src/fcgi_queue.sv */
module fcgi_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  fcgi_pkg::fcgi_entry_t wr_entry,
    output logic                  full,
    input  logic                  rd_en,
    output fcgi_pkg::fcgi_entry_t rd_entry,
    output logic                  not_empty
);

    fcgi_pkg::fcgi_entry_t           mem [fcgi_pkg::Q_DEPTH];
    logic [fcgi_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [fcgi_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [fcgi_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic                            do_wr;
    logic                            do_rd;

    assign full      = cnt_reg == fcgi_pkg::Q_CNT_W'(fcgi_pkg::Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_entry  = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + fcgi_pkg::Q_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + fcgi_pkg::Q_PTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + fcgi_pkg::Q_CNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - fcgi_pkg::Q_CNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

/* src/fcgi_back.sv */
module fcgi_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  fcgi_pkg::fcgi_entry_t q_entry,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output logic [1:0]            phase,
    output logic [7:0]            byte_out,
    output logic                  header_done,
    output logic [7:0]            protocol_version,
    output logic [7:0]            record_type,
    output logic [15:0]           request_id,
    output logic [15:0]           content_length,
    output logic [7:0]            padding_length,
    output logic [15:0]           body_index,
    output logic                  body_last,
    output logic                  record_done
);

    logic [7:0]  ver_reg;
    logic [7:0]  type_reg;
    logic [15:0] rid_reg;
    logic [15:0] clen_reg;
    logic [7:0]  plen_reg;
    logic        out_valid_reg;
    logic [1:0]  phase_reg;
    logic [7:0]  byte_reg;
    logic        hdone_reg;
    logic [7:0]  ver_out_reg;
    logic [7:0]  type_out_reg;
    logic [15:0] rid_out_reg;
    logic [15:0] clen_out_reg;
    logic [7:0]  plen_out_reg;
    logic [15:0] bidx_reg;
    logic        blast_reg;
    logic        done_reg;
    logic        is_hdr;

    // Take the next entry when the output slot is free or being drained
    assign q_rd   = q_not_empty && (!out_valid_reg || pop);
    assign is_hdr = q_entry.phase == fcgi_pkg::PH_HEADER;

    // Capture header bytes in stream order
    always_ff @(posedge clk)
    begin
        if (q_rd && is_hdr)
        begin
            case (q_entry.hdr_pos)
                fcgi_pkg::POS_VERSION: ver_reg          <= q_entry.data;
                fcgi_pkg::POS_TYPE:    type_reg         <= q_entry.data;
                fcgi_pkg::POS_RID_HI:  rid_reg[15:8]    <= q_entry.data;
                fcgi_pkg::POS_RID_LO:  rid_reg[7:0]     <= q_entry.data;
                fcgi_pkg::POS_CLEN_HI: clen_reg[15:8]   <= q_entry.data;
                fcgi_pkg::POS_CLEN_LO: clen_reg[7:0]    <= q_entry.data;
                fcgi_pkg::POS_PLEN:    plen_reg         <= q_entry.data;
                default:               ver_reg          <= ver_reg;
            endcase
        end
    end

    // Load the result slot
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            phase_reg    <= q_entry.phase;
            byte_reg     <= q_entry.data;
            hdone_reg    <= q_entry.hdr_done;
            ver_out_reg  <= q_entry.hdr_done ? ver_reg  : 8'd0;
            type_out_reg <= q_entry.hdr_done ? type_reg : 8'd0;
            rid_out_reg  <= q_entry.hdr_done ? rid_reg  : 16'd0;
            clen_out_reg <= q_entry.hdr_done ? clen_reg : 16'd0;
            plen_out_reg <= q_entry.hdr_done ? plen_reg : 8'd0;
            bidx_reg     <= q_entry.body_index;
            blast_reg    <= q_entry.body_last;
            done_reg     <= q_entry.rec_done;
        end
    end

    // Track result slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign empty            = !out_valid_reg;
    assign phase            = phase_reg;
    assign byte_out         = byte_reg;
    assign header_done      = hdone_reg;
    assign protocol_version = ver_out_reg;
    assign record_type      = type_out_reg;
    assign request_id       = rid_out_reg;
    assign content_length   = clen_out_reg;
    assign padding_length   = plen_out_reg;
    assign body_index       = bidx_reg;
    assign body_last        = blast_reg;
    assign record_done      = done_reg;

endmodule
